### src/lszvg_pkg.sv
package lszvg_pkg;

    // angle constants, Q3.12 radians
    localparam logic signed [16:0] PI_Q12      = 17'sd12868;
    localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;
    localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
    localparam logic signed [16:0] ONE_Q12     = 17'sd4096;

    // cordic start gain and unit, Q1.14
    localparam logic signed [17:0] CORDIC_GAIN = 18'sd9949;
    localparam logic signed [17:0] UNIT_Q14    = 18'sd16384;

    // step counter covers up to sixteen rotations
    localparam int unsigned STEP_W    = 4;
    localparam int unsigned MAX_STEPS = 16;

    // division by ten as multiply by reciprocal, exact below 43699
    localparam logic signed [16:0] RECIP10       = 17'sd52429;
    localparam int unsigned        RECIP10_SHIFT = 19;

    // arctangent of 2^-i in units of 2^-16 rad
    localparam logic signed [16:0] ATAN_Q16 [MAX_STEPS] = '{
        17'sd51472, 17'sd30385, 17'sd16055, 17'sd8150,
        17'sd4091,  17'sd2047,  17'sd1024,  17'sd512,
        17'sd256,   17'sd128,   17'sd64,    17'sd32,
        17'sd16,    17'sd8,     17'sd4,     17'sd2
    };

    typedef enum logic [2:0] {
        REG_START_ANGLE   = 3'd0,
        REG_ANGLE_STEP    = 3'd1,
        REG_FIRST_INDEX   = 3'd2,
        REG_LAST_INDEX    = 3'd3,
        REG_HALF_WIDTH    = 3'd4,
        REG_SAFE_DISTANCE = 3'd5,
        REG_SIDE_LIMIT    = 3'd6,
        REG_FRONT_UPPER   = 3'd7
    } cfg_idx_t;

    // status and results handed back by the sine/cosine unit
    typedef struct packed {
        logic               done;
        logic signed [15:0] sin_val;
        logic signed [15:0] cos_val;
    } cordic_res_t;

endpackage

### src/lszvg_cordic.sv
module lszvg_cordic #(
    parameter int unsigned CORDIC_STEPS = 14
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [15:0]       angle,
    output lszvg_pkg::cordic_res_t   res
);
    import lszvg_pkg::*;

    logic                     busy_reg;
    logic                     fin_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     flip_reg;
    logic signed [17:0]       x_reg;
    logic signed [17:0]       y_reg;
    logic signed [19:0]       z_reg;
    logic signed [15:0]       sin_reg;
    logic signed [15:0]       cos_reg;

    logic signed [16:0]       wrap_angle;
    logic signed [16:0]       fold_angle;
    logic                     fold_flip;
    logic signed [17:0]       x_next;
    logic signed [17:0]       y_next;
    logic signed [19:0]       z_next;

    function automatic logic signed [15:0] clamp_unit(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > UNIT_Q14)
            r = 16'(UNIT_Q14);
        else if (v < -UNIT_Q14)
            r = 16'(-UNIT_Q14);
        else
            r = 16'(v);
        return r;
    endfunction

    // fold the angle into [-pi/2, pi/2]
    always_comb
    begin
        wrap_angle = {angle[15], angle};
        if (wrap_angle > PI_Q12)
            wrap_angle = wrap_angle - TWO_PI_Q12;
        else if (wrap_angle < -PI_Q12)
            wrap_angle = wrap_angle + TWO_PI_Q12;
        fold_flip  = 1'b0;
        fold_angle = wrap_angle;
        if (wrap_angle > HALF_PI_Q12)
        begin
            fold_angle = PI_Q12 - wrap_angle;
            fold_flip  = 1'b1;
        end
        else if (wrap_angle < -HALF_PI_Q12)
        begin
            fold_angle = -PI_Q12 - wrap_angle;
            fold_flip  = 1'b1;
        end
    end

    // one rotation per cycle through the shared add/sub and shift
    always_comb
    begin
        if (z_reg >= 0)
        begin
            x_next = x_reg - (y_reg >>> step_reg);
            y_next = y_reg + (x_reg >>> step_reg);
            z_next = z_reg - 20'(ATAN_Q16[step_reg]);
        end
        else
        begin
            x_next = x_reg + (y_reg >>> step_reg);
            y_next = y_reg - (x_reg >>> step_reg);
            z_next = z_reg + 20'(ATAN_Q16[step_reg]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg && !start && !busy_reg;
            fin_reg  <= busy_reg && !start && (step_reg == STEP_W'(CORDIC_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed(20'({fold_angle, 4'b0000}));
            flip_reg <= fold_flip;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (fin_reg)
        begin
            sin_reg <= clamp_unit(y_reg);
            cos_reg <= clamp_unit(flip_reg ? -x_reg : x_reg);
        end
    end

    assign res.done    = done_reg;
    assign res.sin_val = sin_reg;
    assign res.cos_val = cos_reg;

endmodule

### src/lidar_safety_zone_velocity_guard_unit.sv
// Lidar safety guard: range samples of one scan stream in on the slave side in
// index order, tlast marking the final sample. Each sample inside the index
// window [first_checked_index, last_checked_index] is tested against a right
// side corridor, a front zone and a left side corridor, using its angle
// start_angle + index * angle_step (Q3.12 rad) and sin/cos from an iterative
// CORDIC. The first offending sample latches its angle and stops further
// checks for the scan. On the final sample one transaction leaves on the
// master side: the commanded velocity, or, with the alarm set, linear speed
// divided by ten (toward zero) and angular speed raised by 1.0 (Q3.12) when
// the hit angle is positive, else lowered by 1.0, saturated. A checked sample
// occupies the block while the CORDIC rotates one step per cycle, then for two
// passes through the single shared multiplier and a compare state; an unchecked
// sample, unless final, leaves the block idle; the final sample then passes a
// divide-by-ten multiply state and a result load state that waits for a free
// output register. tready is high only while no sample is in work; a finished
// result waits in the output register while the next sample is taken.
// Configuration writes are always ready and must land while the block is idle.
module lidar_safety_zone_velocity_guard_unit #(
    parameter int unsigned MAX_SAMPLES  = 4096,
    parameter int unsigned CORDIC_STEPS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    // sample transactions
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // range_mm[15:0], cmd_linear[31:16], cmd_angular[47:32]
    input  logic        s_axis_tlast,   // last_sample
    // velocity result transactions
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_linear[15:0], out_angular[31:16],
                                        // obstacle_alarm[32], hit_angle[48:33], zero[55:49]
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lszvg_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_SAMPLES);
    localparam int unsigned IDX_W = (CNT_W > 12) ? CNT_W : 12;

    // one-hot sequencer
    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_CORDIC  = 7'b0000010,
        ST_MUL_SIN = 7'b0000100,
        ST_MUL_COS = 7'b0001000,
        ST_CHECK   = 7'b0010000,
        ST_DIV     = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } state_t;

    state_t state_reg;

    // configuration registers
    logic signed [15:0] start_angle_reg;
    logic [14:0]        angle_step_reg;
    logic [11:0]        first_index_reg;
    logic [11:0]        last_index_reg;
    logic [15:0]        half_width_reg;
    logic [15:0]        safe_distance_reg;
    logic [12:0]        side_limit_reg;
    logic [12:0]        front_upper_reg;

    // scan state
    logic [CNT_W-1:0]   cnt_reg;
    logic [15:0]        acc_reg;
    logic               alarm_reg;
    logic signed [15:0] first_hit_reg;

    // sample in work
    logic [15:0]        range_reg;
    logic               last_reg;
    logic signed [15:0] lin_reg;
    logic signed [15:0] ang_reg;
    logic signed [15:0] a_reg;
    logic signed [33:0] prod_reg;
    logic               side_hit_reg;

    // output register
    logic               out_valid_reg;
    logic [55:0]        out_data_reg;

    logic               in_accept;
    logic               idx_ok;
    logic               check_now;
    logic signed [15:0] a_now;
    logic               cordic_start;
    cordic_res_t        cordic_res;

    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;
    logic signed [16:0] lin_mag;

    logic signed [16:0] a17;
    logic signed [16:0] side17;
    logic signed [16:0] neg_side17;
    logic signed [16:0] front17;
    logic signed [33:0] hw14;
    logic signed [33:0] sd14;
    logic               side_hit;
    logic               front_hit;

    logic [14:0]        quot;
    logic signed [15:0] lin_div;
    logic signed [16:0] ang_sum;
    logic signed [15:0] ang_sat;
    logic signed [15:0] out_lin;
    logic signed [15:0] out_ang;
    logic               out_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // window test and sample angle, modulo 2^16
    assign idx_ok    = (IDX_W'(cnt_reg) >= IDX_W'(first_index_reg)) &&
                       (IDX_W'(cnt_reg) <= IDX_W'(last_index_reg));
    assign check_now = !alarm_reg && idx_ok;
    assign a_now     = start_angle_reg + $signed(acc_reg);
    assign cordic_start = in_accept && check_now;

    lszvg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (a_now),
        .res   (cordic_res)
    );

    // shared multiplier: range by sin, range by cos, |linear| by 1/10
    assign lin_mag = lin_reg[15] ? -{lin_reg[15], lin_reg} : {lin_reg[15], lin_reg};

    always_comb
    begin
        mul_a = $signed({1'b0, range_reg});
        mul_b = {cordic_res.sin_val[15], cordic_res.sin_val};
        case (state_reg)
            ST_MUL_COS:
            begin
                mul_b = {cordic_res.cos_val[15], cordic_res.cos_val};
            end
            ST_DIV:
            begin
                mul_a = lin_mag;
                mul_b = RECIP10;
            end
            default:
            begin
                mul_b = {cordic_res.sin_val[15], cordic_res.sin_val};
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // zone compares, bounds scaled to Q1.14 products
    assign a17        = {a_reg[15], a_reg};
    assign side17     = $signed({4'b0000, side_limit_reg});
    assign neg_side17 = -side17;
    assign front17    = $signed({4'b0000, front_upper_reg});
    assign hw14       = $signed({4'b0000, half_width_reg, 14'b0});
    assign sd14       = $signed({4'b0000, safe_distance_reg, 14'b0});

    // prod_reg holds range*sin here
    assign side_hit  = ((a17 > side17) && (prod_reg < hw14)) ||
                       ((a17 < neg_side17) && (prod_reg > -hw14));
    // prod_reg holds range*cos here
    assign front_hit = (a17 < front17) && (a17 > neg_side17) && (prod_reg < sd14);

    // alarm response
    assign quot    = prod_reg[RECIP10_SHIFT +: 15];
    assign lin_div = lin_reg[15] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign ang_sum = {ang_reg[15], ang_reg} + ((first_hit_reg > 0) ? ONE_Q12 : -ONE_Q12);

    always_comb
    begin
        if (ang_sum > 17'sd32767)
            ang_sat = 16'sh7FFF;
        else if (ang_sum < -17'sd32768)
            ang_sat = 16'sh8000;
        else
            ang_sat = 16'(ang_sum);
    end

    assign out_lin = alarm_reg ? lin_div : lin_reg;
    assign out_ang = alarm_reg ? ang_sat : ang_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg   <= -16'sd12868;
            angle_step_reg    <= 15'd7;
            first_index_reg   <= 12'd0;
            last_index_reg    <= 12'd4095;
            half_width_reg    <= 16'd150;
            safe_distance_reg <= 16'd200;
            side_limit_reg    <= 13'd2635;
            front_upper_reg   <= 13'd3798;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_START_ANGLE:   start_angle_reg   <= $signed(cfg_data);
                REG_ANGLE_STEP:    angle_step_reg    <= cfg_data[14:0];
                REG_FIRST_INDEX:   first_index_reg   <= cfg_data[11:0];
                REG_LAST_INDEX:    last_index_reg    <= cfg_data[11:0];
                REG_HALF_WIDTH:    half_width_reg    <= cfg_data;
                REG_SAFE_DISTANCE: safe_distance_reg <= cfg_data;
                REG_SIDE_LIMIT:    side_limit_reg    <= cfg_data[12:0];
                REG_FRONT_UPPER:   front_upper_reg   <= cfg_data[12:0];
                default:           ;
            endcase
        end
    end

    // sequencer and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            alarm_reg     <= 1'b0;
            first_hit_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the finish state reloads the output register itself
            if (out_valid_reg && m_axis_tready && state_reg != ST_FINISH)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        // advance the index, wrapping after the longest scan
                        if (cnt_reg == CNT_W'(MAX_SAMPLES - 1))
                        begin
                            cnt_reg <= '0;
                            acc_reg <= '0;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                            acc_reg <= acc_reg + {1'b0, angle_step_reg};
                        end
                        if (check_now)
                            state_reg <= ST_CORDIC;
                        else if (s_axis_tlast)
                            state_reg <= ST_DIV;
                    end
                end
                ST_CORDIC:
                begin
                    if (cordic_res.done)
                        state_reg <= ST_MUL_SIN;
                end
                ST_MUL_SIN:
                begin
                    state_reg <= ST_MUL_COS;
                end
                ST_MUL_COS:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (side_hit_reg || front_hit)
                    begin
                        alarm_reg     <= 1'b1;
                        first_hit_reg <= a_reg;
                    end
                    state_reg <= last_reg ? ST_DIV : ST_IDLE;
                end
                ST_DIV:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    // hold until the output register is free, then close the scan
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        cnt_reg       <= '0;
                        acc_reg       <= '0;
                        alarm_reg     <= 1'b0;
                        first_hit_reg <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            range_reg <= s_axis_tdata[15:0];
            lin_reg   <= $signed(s_axis_tdata[31:16]);
            ang_reg   <= $signed(s_axis_tdata[47:32]);
            last_reg  <= s_axis_tlast;
            a_reg     <= a_now;
        end
        if (state_reg == ST_MUL_SIN || state_reg == ST_MUL_COS || state_reg == ST_DIV)
            prod_reg <= mul_p;
        if (state_reg == ST_MUL_COS)
            side_hit_reg <= side_hit;
        if (state_reg == ST_FINISH && out_free)
            out_data_reg <= {7'b0, first_hit_reg, alarm_reg, out_ang, out_lin};
    end

    // the sine/cosine unit only reports back while the sequencer waits on it
    a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_res.done |-> state_reg == ST_CORDIC)
        else $error("cordic completion outside its wait state");

    // the alarm clears only when a scan is closed
    a_alarm_clear_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(alarm_reg) |-> $past(state_reg == ST_FINISH))
        else $error("alarm cleared before the final sample was handled");

    // a latched hit angle is not overwritten within the scan
    a_hit_angle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (alarm_reg && state_reg != ST_FINISH) |=> $stable(first_hit_reg))
        else $error("hit angle changed after the alarm latched");

endmodule

### tb/sv/lszvg_velocity_checker.sv
`timescale 1ns / 1ps

module lszvg_velocity_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // range_mm[15:0], cmd_linear[31:16], cmd_angular[47:32]
    input  logic        s_axis_tlast,   // last_sample
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // out_linear[15:0], out_angular[31:16],
                                        // obstacle_alarm[32], hit_angle[48:33], zero[55:49]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatch_count,
    output int          results_outstanding
);
    import lszvg_pkg::*;

    localparam int HALF_TURN    = 12868;
    localparam int QUARTER_TURN = 6434;
    localparam int FULL_TURN    = 25736;
    localparam int TURN_NUDGE   = 4096;
    localparam int ROT_GAIN     = 9949;
    localparam int SIN_UNIT     = 16384;
    localparam int ROT_STEPS    = 14;
    localparam int SCAN_WRAP    = 4096;
    localparam int PRINT_LIMIT  = 50;

    typedef struct packed {
        logic signed [15:0] hit;
        logic               alarm;
        logic signed [15:0] ang;
        logic signed [15:0] lin;
    } velocity_cmd_t;

    // arctangent of 2^-k, 2^-16 rad
    int arctan_tbl [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};

    logic signed [15:0] start_angle_q;
    logic [14:0]        step_q;
    logic [11:0]        first_idx_q;
    logic [11:0]        last_idx_q;
    logic [15:0]        half_width_q;
    logic [15:0]        safe_dist_q;
    logic [12:0]        side_lim_q;
    logic [12:0]        front_up_q;

    int                 sample_idx;
    logic [15:0]        angle_acc;
    logic               alarm_q;
    logic signed [15:0] hit_angle_q;

    velocity_cmd_t expected_cmds [$];

    task automatic report(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: velocity mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int clamp_unit(input int v);
        if (v > SIN_UNIT)
            return SIN_UNIT;
        if (v < -SIN_UNIT)
            return -SIN_UNIT;
        return v;
    endfunction

    function automatic void cordic_sincos(input int ang, output int sin_v, output int cos_v);
        int x;
        int y;
        int z;
        int dx;
        int dy;
        int k;
        bit mirrored;
        x = ROT_GAIN;
        y = 0;
        mirrored = 1'b0;
        if (ang > HALF_TURN)
            ang -= FULL_TURN;
        if (ang < -HALF_TURN)
            ang += FULL_TURN;
        // fold into the right half plane, remember to negate cos
        if (ang > QUARTER_TURN)
        begin
            ang = HALF_TURN - ang;
            mirrored = 1'b1;
        end
        else if (ang < -QUARTER_TURN)
        begin
            ang = -HALF_TURN - ang;
            mirrored = 1'b1;
        end
        z = ang * 16;
        for (k = 0; k < ROT_STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_tbl[k];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_tbl[k];
            end
        end
        sin_v = clamp_unit(y);
        cos_v = clamp_unit(mirrored ? -x : x);
    endfunction

    function automatic bit in_safety_zone(input int a, input int rng);
        int s;
        int c;
        int side;
        int front;
        longint hw_lim;
        longint sd_lim;
        bit hit;
        cordic_sincos(a, s, c);
        side = int'(side_lim_q);
        front = int'(front_up_q);
        hw_lim = longint'(half_width_q) * SIN_UNIT;
        sd_lim = longint'(safe_dist_q) * SIN_UNIT;
        hit = 1'b0;
        if (a > side && longint'(rng) * s < hw_lim)
            hit = 1'b1;
        if (a < front && a > -side && longint'(rng) * c < sd_lim)
            hit = 1'b1;
        if (a < -side && -(longint'(rng) * s) < hw_lim)
            hit = 1'b1;
        return hit;
    endfunction

    task automatic take_sample(input logic [47:0] data, input logic last);
        int rng;
        int lin;
        int ang;
        int a;
        logic [15:0] angle_bits;
        velocity_cmd_t cmd;
        rng = int'(data[15:0]);
        lin = int'($signed(data[31:16]));
        ang = int'($signed(data[47:32]));
        angle_bits = start_angle_q + angle_acc;
        a = int'($signed(angle_bits));
        if (!alarm_q && sample_idx >= int'(first_idx_q) && sample_idx <= int'(last_idx_q))
        begin
            if (in_safety_zone(a, rng))
            begin
                alarm_q = 1'b1;
                hit_angle_q = angle_bits;
            end
        end
        sample_idx++;
        angle_acc = angle_acc + 16'(step_q);
        if (sample_idx >= SCAN_WRAP)
        begin
            sample_idx = 0;
            angle_acc = '0;
        end
        if (last)
        begin
            if (alarm_q)
            begin
                lin = lin / 10;
                ang += (hit_angle_q > 0) ? TURN_NUDGE : -TURN_NUDGE;
                if (ang > 32767)
                    ang = 32767;
                if (ang < -32768)
                    ang = -32768;
            end
            cmd.lin = lin[15:0];
            cmd.ang = ang[15:0];
            cmd.alarm = alarm_q;
            cmd.hit = alarm_q ? hit_angle_q : 16'sd0;
            expected_cmds.push_back(cmd);
            sample_idx = 0;
            angle_acc = '0;
            alarm_q = 1'b0;
            hit_angle_q = '0;
        end
    endtask

    task automatic check_result(input logic [55:0] data);
        velocity_cmd_t want;
        if (expected_cmds.size() == 0)
        begin
            report($sformatf("result %h with nothing expected", data));
            return;
        end
        want = expected_cmds.pop_front();
        if (data[15:0] !== want.lin)
            report($sformatf("out_linear %0d, expected %0d",
                             $signed(data[15:0]), want.lin));
        if (data[31:16] !== want.ang)
            report($sformatf("out_angular %0d, expected %0d",
                             $signed(data[31:16]), want.ang));
        if (data[32] !== want.alarm)
            report($sformatf("obstacle_alarm %b, expected %b", data[32], want.alarm));
        if (data[48:33] !== want.hit)
            report($sformatf("hit_angle %0d, expected %0d",
                             $signed(data[48:33]), want.hit));
        if (data[55:49] !== 7'd0)
            report($sformatf("padding bits %b not zero", data[55:49]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_q = -16'sd12868;
            step_q = 15'd7;
            first_idx_q = 12'd0;
            last_idx_q = 12'd4095;
            half_width_q = 16'd150;
            safe_dist_q = 16'd200;
            side_lim_q = 13'd2635;
            front_up_q = 13'd3798;
            sample_idx = 0;
            angle_acc = '0;
            alarm_q = 1'b0;
            hit_angle_q = '0;
            expected_cmds.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_START_ANGLE:   start_angle_q = cfg_data;
                    REG_ANGLE_STEP:    step_q = cfg_data[14:0];
                    REG_FIRST_INDEX:   first_idx_q = cfg_data[11:0];
                    REG_LAST_INDEX:    last_idx_q = cfg_data[11:0];
                    REG_HALF_WIDTH:    half_width_q = cfg_data;
                    REG_SAFE_DISTANCE: safe_dist_q = cfg_data;
                    REG_SIDE_LIMIT:    side_lim_q = cfg_data[12:0];
                    REG_FRONT_UPPER:   front_up_q = cfg_data[12:0];
                    default: ;
                endcase
            end
            // compare before the new sample so a fresh expectation is never matched early
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                take_sample(s_axis_tdata, s_axis_tlast);
        end
        results_outstanding = expected_cmds.size();
    end

endmodule

### tb/sv/lidar_safety_zone_velocity_guard_unit_test.sv
`timescale 1ns / 1ps

module lidar_safety_zone_velocity_guard_unit_test;
    import lszvg_pkg::*;

    // cycles a checked sample can still be in work after its transaction
    localparam int SETTLE_CYCLES = 40;
    // bound on waiting for outstanding results, covers the long sink hold
    localparam int DRAIN_LIMIT   = 20000;
    // length of the forced sink hold
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 120;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;     // range_mm[15:0], cmd_linear[31:16], cmd_angular[47:32]
    logic        s_axis_tlast = 1'b0;   // last_sample

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // out_linear[15:0], out_angular[31:16],
                                        // obstacle_alarm[32], hit_angle[48:33], zero[55:49]

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int          mismatch_count;
    int          results_outstanding;

    // idling mode: steady turns off random gaps on both sides
    logic        steady = 1'b0;
    // asks the sink for one long hold
    logic        hold_off_req = 1'b0;

    // bounds currently programmed, used to aim ranges near the alarm thresholds
    int unsigned cur_hw = 150;
    int unsigned cur_sd = 200;

    lidar_safety_zone_velocity_guard_unit DUT (.*);

    lszvg_velocity_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #1500000;
        $display("FAIL lidar_safety_zone_velocity_guard_unit");
        $finish;
    end

    // result sink: random backpressure, one long hold on request
    initial
    begin : sink
        int unsigned hold;
        bit hold_used;
        hold = 0;
        hold_used = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_used)
            begin
                hold = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold != 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (steady)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 27);
        end
    end

    // one sample transaction, with random gaps ahead of it
    task automatic send_sample(input logic [15:0] rng, input logic last,
                               input logic [15:0] lin, input logic [15:0] ang);
        while (!steady && $urandom_range(99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ang, lin, rng};
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // valid is left high so back-to-back writes never drop it within a step
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // wait until every expected result has left, then let the last sample finish
    task automatic settle_guard();
        int unsigned waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (results_outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // full register set, written only once the block is idle
    task automatic program_guard(input logic signed [15:0] start, input logic [14:0] step,
                                 input logic [11:0] first, input logic [11:0] last,
                                 input logic [15:0] hw, input logic [15:0] sd,
                                 input logic [12:0] side, input logic [12:0] front);
        settle_guard();
        write_reg(REG_START_ANGLE, start);
        write_reg(REG_ANGLE_STEP, {1'b0, step});
        write_reg(REG_FIRST_INDEX, {4'd0, first});
        write_reg(REG_LAST_INDEX, {4'd0, last});
        write_reg(REG_HALF_WIDTH, hw);
        write_reg(REG_SAFE_DISTANCE, sd);
        write_reg(REG_SIDE_LIMIT, {3'd0, side});
        write_reg(REG_FRONT_UPPER, {3'd0, front});
        cfg_valid <= 1'b0;
        cur_hw = hw;
        cur_sd = sd;
    endtask

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned sent;
        int unsigned len;
        int unsigned k;
        int unsigned roll;
        int unsigned bound;
        int unsigned scaled;
        logic [15:0] rng;
        logic signed [15:0] r_start;
        logic [14:0] r_step;
        logic [11:0] r_first;
        logic [11:0] r_last;
        logic [15:0] r_hw;
        logic [15:0] r_sd;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: sample zero sits at -pi, right corridor, sin near zero
        send_sample(16'd0, 1'b1, 16'h8000, 16'h8000);      // negative saturation
        send_sample(16'hFFFF, 1'b1, 16'h7FFF, 16'h7FFF);
        send_sample(16'hFFFF, 1'b0, 16'h0000, 16'h0000);
        send_sample(16'd100, 1'b0, 16'hFFFF, 16'hFFFF);
        send_sample(16'd12345, 1'b1, 16'hFFF9, 16'h0005);

        // left corridor hit with positive angle, positive saturation
        program_guard(16'sd3000, 15'd0, 12'd0, 12'd4095, 16'd150, 16'd200,
                      13'd2635, 13'd3798);
        send_sample(16'd0, 1'b1, 16'hFFFF, 16'h7FFF);
        // far obstacle, command passes unchanged
        send_sample(16'hFFFF, 1'b1, 16'd12345, 16'hCFC7);

        // hit exactly at angle zero turns negative
        program_guard(16'sd0, 15'd0, 12'd0, 12'd4095, 16'd150, 16'd200,
                      13'd2635, 13'd3798);
        send_sample(16'd0, 1'b1, 16'd100, 16'd0);

        // empty index window: nothing checked
        program_guard(16'sd0, 15'd0, 12'd10, 12'd5, 16'd150, 16'd200,
                      13'd2635, 13'd3798);
        send_sample(16'd0, 1'b0, 16'd1, 16'd1);
        send_sample(16'd0, 1'b0, 16'd2, 16'd2);
        send_sample(16'd0, 1'b1, 16'd300, 16'd300);

        // angle exactly at the side limit is only a front candidate
        program_guard(16'sd2635, 15'd0, 12'd0, 12'd4095, 16'hFFFF, 16'd0,
                      13'd2635, 13'd3798);
        send_sample(16'd1000, 1'b1, 16'd40, 16'd40);

        // angle exactly at minus the side limit falls in no zone
        program_guard(-16'sd2635, 15'd0, 12'd0, 12'd4095, 16'hFFFF, 16'hFFFF,
                      13'd2635, 13'd3798);
        send_sample(16'd0, 1'b1, 16'd1, 16'd1);

        // overlapping zones: front test alone raises the alarm
        program_guard(16'sd3000, 15'd0, 12'd0, 12'd4095, 16'd0, 16'hFFFF,
                      13'd1000, 13'd5000);
        send_sample(16'd100, 1'b1, 16'h1234, 16'h4321);

        // start angle, step and bounds at their top values, full window, limits at pi/2
        program_guard(16'sd32767, 15'h7FFF, 12'd0, 12'd4095, 16'hFFFF, 16'hFFFF,
                      13'd6434, 13'd6434);
        send_sample(16'd500, 1'b0, 16'h5555, 16'hAAAA);
        send_sample(16'hFFFF, 1'b0, 16'hAAAA, 16'h5555);
        send_sample(16'd3, 1'b0, 16'h0F0F, 16'hF0F0);
        send_sample(16'h8000, 1'b1, 16'h7FF6, 16'h8001);

        // all registers at their bottom values
        program_guard(-16'sd32768, 15'd0, 12'd0, 12'd0, 16'd0, 16'd0, 13'd0, 13'd0);
        send_sample(16'd0, 1'b0, 16'd0, 16'd0);
        send_sample(16'd0, 1'b1, 16'hFFF6, 16'hF000);

        // random settings and scans
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            r_start = 16'($urandom);
            roll = $urandom_range(99);
            if (roll < 60)
                r_step = 15'($urandom_range(300));
            else if (roll < 90)
                r_step = 15'($urandom_range(4000));
            else
                r_step = 15'($urandom);
            r_last = ($urandom_range(99) < 60) ? 12'd4095 : 12'($urandom_range(60));
            r_first = ($urandom_range(99) < 70) ? 12'd0 : 12'($urandom_range(30));
            r_hw = ($urandom_range(99) < 85) ? 16'($urandom_range(3000)) : 16'($urandom);
            r_sd = ($urandom_range(99) < 85) ? 16'($urandom_range(3000)) : 16'($urandom);
            program_guard(r_start, r_step, r_first, r_last, r_hw, r_sd,
                          13'($urandom_range(6434)), 13'($urandom_range(6434)));

            // one phase with a long sink hold while samples keep coming
            if (phase == 2)
                hold_off_req <= 1'b1;
            // one phase with no gaps on either side
            steady <= (phase == 4);

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (roll < 10)
                    len = 1;
                else if (roll < 75)
                    len = $urandom_range(8, 2);
                else if (roll < 95)
                    len = $urandom_range(40, 9);
                else
                    len = $urandom_range(300, 100);
                for (k = 0; k < len; k++)
                begin
                    // small ranges, ranges around the thresholds, or anything
                    roll = $urandom_range(99);
                    if (roll < 35)
                        rng = 16'($urandom_range(600));
                    else if (roll < 70)
                    begin
                        bound = $urandom_range(1) ? cur_hw : cur_sd;
                        scaled = (bound * $urandom_range(48, 16)) / 16 + $urandom_range(20);
                        rng = (scaled > 65535) ? 16'hFFFF : scaled[15:0];
                    end
                    else
                        rng = 16'($urandom);
                    send_sample(rng, k == len - 1, 16'($urandom), 16'($urandom));
                end
                sent += len;
            end
        end

        settle_guard();
        if (results_outstanding != 0)
            $display("%0d velocity results never arrived", results_outstanding);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("PASS lidar_safety_zone_velocity_guard_unit");
        else
            $display("FAIL lidar_safety_zone_velocity_guard_unit");
        $finish;
    end

endmodule

### lidar_safety_zone_velocity_guard_unit.f
src/lszvg_pkg.sv
src/lszvg_cordic.sv
src/lidar_safety_zone_velocity_guard_unit.sv
tb/sv/lszvg_velocity_checker.sv
tb/sv/lidar_safety_zone_velocity_guard_unit_test.sv
